[src/scfoc_pkg.sv]
// shared types and constants of the serial command frame output controller
`timescale 1ns / 1ps

package scfoc_pkg;

  // channel and frame layout
  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = $clog2(NUM_CHANNELS);
  localparam int FRAME_BYTES  = 9;
  localparam int FCNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int PULSE_W      = 24;

  // frame marks
  localparam logic [7:0] START_MARK   = 8'hA0;
  localparam logic [7:0] LENGTH_MARK  = 8'h09;
  localparam logic [7:0] CMD_MARK     = 8'h0B;
  localparam logic [7:0] END_MARK     = 8'hB0;
  localparam logic [7:0] REPLY_LENGTH = 8'h07;
  localparam logic [7:0] STATUS_TIMED = 8'h02;

  // register defaults and indexes
  localparam logic [7:0] GAP_DEFAULT   = 8'd5;
  localparam logic [7:0] TICKS_DEFAULT = 8'd20;
  localparam int         CFG_ADDR_W    = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP_TICKS      = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_TICKS_PER_UNIT = 1'b1;

  // input and result codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // reply serializer
  localparam int         REPLY_BYTES = 7;
  localparam int         BEAT_W      = $clog2(REPLY_BYTES);
  localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(REPLY_BYTES - 1);

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one queued request: a level update or a whole reply
  typedef struct packed {
    logic                    kind;
    logic [NUM_CHANNELS-1:0] pins;
    logic [7:0]              b0;
    logic [7:0]              b2;
    logic [7:0]              b3;
    logic [7:0]              b4;
    logic [7:0]              b5;
  } entry_t;

endpackage

[src/scfoc_front.sv]
// front end: frame capture, gap timing, frame check, channel levels and pulse timers
`timescale 1ns / 1ps

module scfoc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            op,
  input  logic [7:0]                      rx_byte,
  input  logic                            cfg_we,
  input  logic [scfoc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]                      cfg_wdata,
  output logic                            push,
  output scfoc_pkg::entry_t               push_entry
);
  import scfoc_pkg::*;

  logic [7:0]                 gap_ticks;
  logic [7:0]                 ticks_per_unit;
  logic [7:0]                 frame_store [FRAME_BYTES];
  logic [FCNT_W-1:0]          byte_count;
  logic [7:0]                 gap_count;
  logic                       frame_pending;
  logic [NUM_CHANNELS-1:0]    levels;
  logic [NUM_CHANNELS-1:0]    pulse_active;
  logic [PULSE_W-1:0]         pulse_elapsed [NUM_CHANNELS];
  logic [PULSE_W-1:0]         pulse_length [NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0]    levels_next;
  logic [NUM_CHANNELS-1:0]    active_next;
  logic [PULSE_W-1:0]         elapsed_next [NUM_CHANNELS];
  logic [PULSE_W-1:0]         length_next [NUM_CHANNELS];

  logic                       tick;
  logic [7:0]                 gap_limit;
  logic [7:0]                 gap_inc;
  logic                       ended;
  logic                       frame_ok;
  logic [7:0]                 or7;
  logic [7:0]                 or5;
  logic                       ch_hit;
  logic [CH_W-1:0]            ch;
  logic [PULSE_W-1:0]         product;

  assign tick = accept && (op == OP_TICK);

  // frame check on the stored bytes
  assign or5 = frame_store[0] | frame_store[1] | frame_store[2] | frame_store[3]
             | frame_store[4];
  assign or7 = or5 | frame_store[5] | frame_store[6];
  assign frame_ok = (frame_store[0] == START_MARK) && (frame_store[1] == LENGTH_MARK)
                 && (frame_store[2] == CMD_MARK) && (frame_store[8] == END_MARK)
                 && (frame_store[7] == or7);
  assign ch_hit  = (frame_store[3] < 8'(NUM_CHANNELS));
  assign ch      = frame_store[3][CH_W-1:0];
  assign product = PULSE_W'({frame_store[6], frame_store[5]}) * PULSE_W'(ticks_per_unit);

  // gap counting, a zero limit acts like one
  assign gap_limit = (gap_ticks == 8'd0) ? 8'd1 : gap_ticks;
  assign gap_inc   = (gap_count == 8'hFF) ? gap_count : gap_count + 8'd1;
  assign ended     = tick && frame_pending && (gap_inc >= gap_limit);

  // channel action then pulse timers
  always_comb begin
    logic [PULSE_W-1:0] e;
    levels_next = levels;
    active_next = pulse_active;
    e           = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      elapsed_next[c] = pulse_elapsed[c];
      length_next[c]  = pulse_length[c];
    end
    if (ended && frame_ok && ch_hit) begin
      if (frame_store[4] != STATUS_TIMED) begin
        levels_next[ch] = frame_store[4][0];
      end else begin
        length_next[ch]  = product;
        elapsed_next[ch] = '0;
        active_next[ch]  = 1'b1;
        levels_next[ch]  = 1'b1;
      end
    end
    if (tick) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (active_next[c] && (length_next[c] != '0)) begin
          e = elapsed_next[c] + PULSE_W'(1);
          if (e == length_next[c]) begin
            levels_next[c]  = 1'b0;
            active_next[c]  = 1'b0;
            elapsed_next[c] = '0;
          end else begin
            elapsed_next[c] = e;
          end
        end
      end
    end
  end

  // request toward the back end
  assign push = ended || (tick && (levels_next != levels));
  always_comb begin
    push_entry.kind = ended ? KIND_REPLY : KIND_LEVEL;
    push_entry.pins = levels_next;
    push_entry.b0   = frame_store[0];
    push_entry.b2   = frame_store[2];
    push_entry.b3   = frame_store[3];
    push_entry.b4   = frame_store[4];
    push_entry.b5   = or5;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks      <= GAP_DEFAULT;
      ticks_per_unit <= TICKS_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GAP_TICKS:      gap_ticks      <= cfg_wdata;
        REG_TICKS_PER_UNIT: ticks_per_unit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame store and gap state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_BYTES; i++) frame_store[i] <= '0;
      byte_count    <= '0;
      gap_count     <= '0;
      frame_pending <= 1'b0;
    end else if (accept && (op == OP_BYTE)) begin
      if (byte_count < FCNT_W'(FRAME_BYTES)) begin
        frame_store[byte_count] <= rx_byte;
        byte_count              <= byte_count + FCNT_W'(1);
      end
      frame_pending <= 1'b1;
      gap_count     <= '0;
    end else if (ended) begin
      frame_store[1] <= REPLY_LENGTH;
      frame_store[5] <= or5;
      frame_store[6] <= END_MARK;
      byte_count     <= '0;
      gap_count      <= '0;
      frame_pending  <= 1'b0;
    end else if (tick && frame_pending) begin
      gap_count <= gap_inc;
    end
  end

  // levels and pulse timers
  always_ff @(posedge clk) begin
    if (rst) begin
      levels       <= '0;
      pulse_active <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pulse_elapsed[c] <= '0;
        pulse_length[c]  <= '0;
      end
    end else if (tick) begin
      levels       <= levels_next;
      pulse_active <= active_next;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pulse_elapsed[c] <= elapsed_next[c];
        pulse_length[c]  <= length_next[c];
      end
    end
  end

  // a frame never ends without a pending frame
  assert property (@(posedge clk) disable iff (rst) ended |-> frame_pending)
    else $error("frame end without pending frame");
  // byte count never passes the frame size
  assert property (@(posedge clk) disable iff (rst)
                   byte_count <= FCNT_W'(FRAME_BYTES))
    else $error("byte count overflow");
  // after a frame end the next frame starts empty
  assert property (@(posedge clk) disable iff (rst)
                   ended |=> (byte_count == '0) && !frame_pending)
    else $error("frame state not cleared at frame end");

endmodule

[src/scfoc_queue.sv]
// short request queue between front and back ends
`timescale 1ns / 1ps

module scfoc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  scfoc_pkg::entry_t push_entry,
  input  logic              pop,
  output scfoc_pkg::entry_t head,
  output logic              empty,
  output logic              full
);
  import scfoc_pkg::*;

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // no request written into a full queue
  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

endmodule

[src/scfoc_back.sv]
// back end: turns queued requests into result beats
`timescale 1ns / 1ps

module scfoc_back (
  input  logic              clk,
  input  logic              rst,
  input  scfoc_pkg::entry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,
  output logic              m_tuser,
  output logic              m_tlast
);
  import scfoc_pkg::*;

  logic [BEAT_W-1:0] beat;
  logic [7:0]        reply_byte;
  logic              done;

  // pick the reply byte of this beat
  always_comb begin
    case (beat)
      BEAT_W'(0): reply_byte = head.b0;
      BEAT_W'(1): reply_byte = REPLY_LENGTH;
      BEAT_W'(2): reply_byte = head.b2;
      BEAT_W'(3): reply_byte = head.b3;
      BEAT_W'(4): reply_byte = head.b4;
      BEAT_W'(5): reply_byte = head.b5;
      BEAT_W'(6): reply_byte = END_MARK;
      default:    reply_byte = 8'd0;
    endcase
  end

  assign m_tvalid = !empty;
  assign m_tuser  = head.kind;
  assign m_tlast  = (head.kind == KIND_LEVEL) || (beat == BEAT_LAST);
  assign m_tdata  = {4'd0, (head.kind == KIND_REPLY) ? reply_byte : 8'd0, head.pins};
  assign done     = m_tvalid && m_tready;
  assign pop      = done && m_tlast;

  // beat counter within a reply
  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= '0;
    end else if (done) begin
      beat <= m_tlast ? '0 : beat + BEAT_W'(1);
    end
  end

  // beat counter stays within one reply
  assert property (@(posedge clk) disable iff (rst) beat <= BEAT_LAST)
    else $error("reply beat out of range");
  // a started reply is only ever held by a reply request
  assert property (@(posedge clk) disable iff (rst)
                   (beat != '0) |-> (!empty && (head.kind == KIND_REPLY)))
    else $error("beat count without reply request");

endmodule

[src/serial_command_frame_output_controller.sv]
// top level of the serial command frame output controller
`timescale 1ns / 1ps

// Received bytes (tuser 0) and timer ticks (tuser 1) are taken one per cycle
// whenever the internal four-entry request queue has room. A byte never
// leaves a request, nor does a tick that changes nothing; a tick that ends a
// frame queues a reply, sent as seven beats with tlast on the seventh, and
// any other tick that changes the output levels queues a single level beat.
// The front end handles each item in the cycle it is accepted; only a stalled
// output side, or replies coming faster than their beats are sent, fills the
// queue and lowers s_tready. Configuration writes take effect on the next
// cycle and should be made while the block is idle.
module serial_command_frame_output_controller (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
  input  logic                             s_tuser,   // [0] op
  // results
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,   // [3:0] pins, [11:4] reply_byte
  output logic                             m_tuser,   // [0] kind
  output logic                             m_tlast,
  // configuration
  input  logic                             cfg_we,
  input  logic [scfoc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]                       cfg_wdata
);
  import scfoc_pkg::*;

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t head;
  logic   empty;
  logic   full;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  // item handling
  scfoc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (s_tuser),
    .rx_byte    (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .push_entry (push_entry)
  );

  // request queue
  scfoc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  // result output
  scfoc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
